// ----- sv/bmr_pkg.sv -----
// Shared types and constants for the button macro recorder/player.
// No dependencies; imported by every module of the block.
package bmr_pkg;

    localparam int unsigned MACRO_DEPTH_DEF = 256;
    localparam logic [15:0] HOLD_RESET      = 16'd1000;

    // APB register map: register index is paddr[2]
    localparam int unsigned APB_AW             = 3;
    localparam logic        REG_HOLD_THRESHOLD = 1'b0;

    localparam int unsigned IN_TDATA_W  = 24;
    localparam int unsigned OUT_TDATA_W = 24;

    // one stored step: mask held for dur ticks
    typedef struct packed {
        logic [15:0] mask;
        logic [31:0] dur;
    } t_entry;

    // one result beat, merged_buttons in the low bits
    typedef struct packed {
        logic        store_full;
        logic        is_playing;
        logic        is_recording;
        logic [15:0] merged_buttons;
    } t_result;

    localparam int unsigned RESULT_W = $bits(t_result);

endpackage

// ----- sv/bmr_store.sv -----
// Macro step store: one write port, one read port, registered read data.
// Depends on bmr_pkg (t_entry). Write-to-read bypass for same-edge collisions.
module bmr_store
    import bmr_pkg::*;
#(
    parameter int unsigned DEPTH = MACRO_DEPTH_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;
    t_entry r_fwd_data;
    logic   r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata    <= r_mem[i_raddr];
        r_fwd_data <= i_wdata;
    end

    // old data comes out of the array on a same-address write; take the new word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else begin
            r_fwd <= i_we && (i_waddr == i_raddr);
        end
    end

    assign o_rdata = r_fwd ? r_fwd_data : r_rdata;

endmodule

// ----- sv/bmr_outq.sv -----
// Two-deep output queue (output register plus skid stage) for result beats.
// Depends on bmr_pkg (t_result).
module bmr_outq
    import bmr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_pop_ready
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out_data;
    t_result r_skid_data;
    logic    pop;

    assign pop     = r_out_valid && i_pop_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (i_push) begin
                r_out_data <= i_data;
            end
        end else if (i_push) begin
            if (r_out_valid) begin
                r_skid_data <= i_data;
            end else begin
                r_out_data <= i_data;
            end
        end
    end

endmodule

// ----- sv/button_macro_recorder_player_top.sv -----
// Button macro recorder/player, top level: tick control, APB register, stream ports.
// Depends on bmr_pkg, bmr_store and bmr_outq.
//
// Each input beat is one millisecond tick carrying the start button level (bit 0) and
// the manual button mask (bits 16:1); each tick yields exactly one result beat with the
// manual mask ORed with the playback mask plus recording, playing and store-full flags.
// A start press held more than hold_threshold ticks (APB byte address 0, reset 1000)
// toggles recording; a shorter press starts playback when the store is not empty.
// Recording appends {previous mask, ticks held} on every mask change and the current
// mask when it stops; appends beyond MACRO_DEPTH entries are dropped. While o_s_tready
// is high the block takes one tick per clock, back to back: the store is read with the
// next play position at the same edge that updates the control state, so the entry at the
// play position is ready in the following cycle, and a write to that same entry is
// bypassed. There is no clearing pass after reset; only entries written by the current
// recording are read. Result beats go through a two-deep output queue, so o_s_tready
// only drops when two results are waiting on the master side.
module button_macro_recorder_player_top
    import bmr_pkg::*;
#(
    parameter int unsigned MACRO_DEPTH = MACRO_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave stream: [0] start_pressed, [16:1] manual_buttons, [23:17] zero
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // master stream: [15:0] merged_buttons, [16] is_recording, [17] is_playing,
    // [18] store_full, [23:19] zero
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    // APB configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_AW-1:0]      paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int unsigned AW = $clog2(MACRO_DEPTH);
    localparam int unsigned CW = $clog2(MACRO_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(MACRO_DEPTH);

    // configuration
    logic [15:0] r_hold;

    // control state
    logic          r_rec, n_rec;
    logic          r_play, n_play;
    logic          r_pa, n_pa;
    logic [15:0]   r_pt, n_pt;
    logic [15:0]   r_lb, n_lb;
    logic [31:0]   r_sc, n_sc;
    logic [31:0]   r_wait, n_wait;
    logic [15:0]   r_mb, n_mb;
    logic [CW-1:0] r_ec, n_ec;
    logic [CW-1:0] r_pi, n_pi;

    // tick decode
    logic        acc;
    logic        pressed;
    logic [15:0] manual;

    // store access
    logic          wr_en;
    logic [CW-1:0] wr_cnt;
    t_entry        wr_data;
    t_entry        rd_data;
    t_entry        head;
    t_result       res;

    assign pready  = 1'b1;
    assign acc     = i_s_tvalid && o_s_tready;
    assign pressed = i_s_tdata[0];
    assign manual  = i_s_tdata[16:1];

    // APB register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= HOLD_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == REG_HOLD_THRESHOLD)) begin
            r_hold <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == REG_HOLD_THRESHOLD) ? {16'h0000, r_hold} : 32'h0;

    // per-tick update; at most one append happens in a tick
    always_comb begin
        n_rec   = r_rec;
        n_play  = r_play;
        n_pa    = r_pa;
        n_pt    = r_pt;
        n_lb    = r_lb;
        n_sc    = r_sc;
        n_wait  = r_wait;
        n_mb    = r_mb;
        n_ec    = r_ec;
        n_pi    = r_pi;
        wr_en   = 1'b0;
        wr_cnt  = r_ec;
        wr_data = '{mask: manual, dur: r_sc};
        head    = rd_data;

        if (acc) begin
            if (r_wait != 32'd0) begin
                n_wait = r_wait - 32'd1;
            end
            if (r_rec && (r_sc != 32'hFFFF_FFFF)) begin
                n_sc = r_sc + 32'd1;
            end
            if (r_pa && (r_pt != 16'hFFFF)) begin
                n_pt = r_pt + 16'd1;
            end

            // start button: evaluated on release
            if (pressed) begin
                if (!r_pa) begin
                    n_pa = 1'b1;
                    n_pt = 16'd0;
                end
            end else if (r_pa) begin
                if (n_pt > r_hold) begin
                    n_rec = !r_rec;
                    if (!r_rec) begin
                        n_ec = '0;
                        n_lb = manual;
                        n_sc = 32'd0;
                    end else begin
                        if (r_ec < DEPTH_C) begin
                            wr_en   = 1'b1;
                            wr_cnt  = r_ec;
                            wr_data = '{mask: manual, dur: n_sc};
                            n_ec    = r_ec + 1'b1;
                        end
                        n_sc = 32'd0;
                    end
                end else if (r_ec != '0) begin
                    n_play = 1'b1;
                end
                n_pa = 1'b0;
                n_pt = 16'd0;
            end

            // mask change while recording
            if (n_rec && (manual != n_lb)) begin
                if (n_ec < DEPTH_C) begin
                    wr_en   = 1'b1;
                    wr_cnt  = n_ec;
                    wr_data = '{mask: n_lb, dur: n_sc};
                    n_ec    = n_ec + 1'b1;
                end
                n_sc = 32'd0;
                n_lb = manual;
            end

            // entry written this tick at the play position is not in the store yet
            if (wr_en && (wr_cnt == r_pi)) begin
                head = wr_data;
            end

            // playback step
            if (n_play && (n_wait == 32'd0)) begin
                if ((r_pi >= n_ec) || (r_pi >= DEPTH_C)) begin
                    n_play = 1'b0;
                    n_pi   = '0;
                    n_mb   = 16'd0;
                end else begin
                    n_mb   = head.mask;
                    n_wait = head.dur;
                    n_pi   = r_pi + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec  <= 1'b0;
            r_play <= 1'b0;
            r_pa   <= 1'b0;
            r_pt   <= 16'd0;
            r_lb   <= 16'd0;
            r_sc   <= 32'd0;
            r_wait <= 32'd0;
            r_mb   <= 16'd0;
            r_ec   <= '0;
            r_pi   <= '0;
        end else begin
            r_rec  <= n_rec;
            r_play <= n_play;
            r_pa   <= n_pa;
            r_pt   <= n_pt;
            r_lb   <= n_lb;
            r_sc   <= n_sc;
            r_wait <= n_wait;
            r_mb   <= n_mb;
            r_ec   <= n_ec;
            r_pi   <= n_pi;
        end
    end

    // read address follows the next play position so the entry is ready next tick
    bmr_store #(
        .DEPTH (MACRO_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (wr_en),
        .i_waddr (wr_cnt[AW-1:0]),
        .i_wdata (wr_data),
        .i_raddr (n_pi[AW-1:0]),
        .o_rdata (rd_data)
    );

    always_comb begin
        res.merged_buttons = manual | n_mb;
        res.is_recording   = n_rec;
        res.is_playing     = n_play;
        res.store_full     = (n_ec == DEPTH_C);
    end

    t_result q_data;

    bmr_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (acc),
        .i_data      (res),
        .o_ready     (o_s_tready),
        .o_valid     (o_m_tvalid),
        .o_data      (q_data),
        .i_pop_ready (i_m_tready)
    );

    assign o_m_tdata = {(OUT_TDATA_W - RESULT_W)'(0), q_data};

endmodule

// ----- sv/bmr_checker.sv -----
// Port-level checks for the button macro recorder/player top level.
// Depends on bmr_pkg; bound to button_macro_recorder_player_top below.
module bmr_checker
    import bmr_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata,
    input logic                   psel,
    input logic                   penable,
    input logic                   pwrite,
    input logic [APB_AW-1:0]      paddr,
    input logic [31:0]            pwdata,
    input logic [31:0]            prdata
);

    // nothing waits on the master side right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result beat present after reset");

    // slave side only stalls when a result is pending on the master side
    a_stall_backed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with no result pending");

    // a stalled result beat holds
    a_hold_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result beat changed while stalled");

    // threshold write reads back on the next cycle
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && (paddr[2] == REG_HOLD_THRESHOLD))
        ##1 ((paddr[2] == REG_HOLD_THRESHOLD) && !(psel && penable && pwrite))
        |-> (prdata == {16'h0000, $past(pwdata[15:0])}))
        else $error("hold threshold readback mismatch");

endmodule

bind button_macro_recorder_player_top bmr_checker u_bmr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata)
);
